>>> rtl/core/atan2_full_circle_approx_core_macros.svh
// ---------------------------------------------------------------------------
// atan2_full_circle_approx_core assertion macros
// Clocked property shorthands. clk_i and rst_ni must be in scope.
// ---------------------------------------------------------------------------
`ifndef ATAN2_FULL_CIRCLE_APPROX_CORE_MACROS_SVH
`define ATAN2_FULL_CIRCLE_APPROX_CORE_MACROS_SVH

// same-cycle implication
`define AFC_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/atan2_fca_pkg.sv
// ---------------------------------------------------------------------------
// atan2_fca_pkg
// Shared types, Q30 constants and rounding helpers for the atan2 core.
// ---------------------------------------------------------------------------
`default_nettype none

package atan2_fca_pkg;

  localparam int WQ         = 30;            // fraction bits of z and poly
  localparam int DIV_BPS    = 2;             // quotient bits per divider stage
  localparam int DIV_STAGES = WQ / DIV_BPS;
  localparam int HW         = 32;            // signed Q30 working word
  localparam int MW         = HW - 1;        // magnitude of HW word
  localparam int PW         = 2 * MW;        // product width
  localparam int AW         = 34;            // unsigned angle word, Q30
  localparam int SW         = AW + 1;        // signed angle word
  localparam int OUT_W      = 16;

  localparam logic [17:0] TAN_PI8_Q16  = 18'd27146;
  localparam logic [17:0] TAN_3PI8_Q16 = 18'd158218;

  localparam logic signed [HW-1:0] C7_Q30 = 32'sd86476423;
  localparam logic signed [HW-1:0] C5_Q30 = 32'sd149010514;
  localparam logic signed [HW-1:0] C3_Q30 = 32'sd214509035;
  localparam logic signed [HW-1:0] C1_Q30 = 32'sd357909816;

  localparam logic [AW-1:0] PI4_Q30   = 34'd843314857;
  localparam logic [AW-1:0] PI2_Q30   = 34'd1686629713;
  localparam logic [AW-1:0] PI_Q30    = 34'd3373259426;
  localparam logic [AW-1:0] TWOPI_Q30 = 34'd6746518852;

  localparam logic [PW-1:0] HALF_WQ = PW'(1) << (WQ - 1);

  // offset applied after the polynomial
  typedef enum logic [1:0] {
    OFS_ZERO,
    OFS_PI4_ADD,
    OFS_PI4_SUB,
    OFS_PI2_SUB
  } ofs_e;

  typedef struct packed {
    logic zero_x;
    logic x_neg;
    logic y_neg;
    ofs_e ofs;
  } meta_t;

  // round a Q60 product back to a Q30 magnitude, half away from zero
  function automatic logic [MW-1:0] rnd_mag(input logic [PW-1:0] p);
    logic [PW-1:0] t;
    t = p + HALF_WQ;
    return t[WQ+MW-1:WQ];
  endfunction

  function automatic logic signed [HW-1:0] mul_round(input logic neg,
                                                     input logic [PW-1:0] p);
    logic signed [HW-1:0] r;
    r = $signed({1'b0, rnd_mag(p)});
    return neg ? -r : r;
  endfunction

  function automatic logic [MW-1:0] mag_of(input logic signed [HW-1:0] h);
    logic signed [HW-1:0] n;
    n = -h;
    return h[HW-1] ? n[MW-1:0] : h[MW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/atan2_fca_reduce.sv
// ---------------------------------------------------------------------------
// atan2_fca_reduce
// Magnitudes, octant thresholds and divider operand selection (3 stages).
// ---------------------------------------------------------------------------
`default_nettype none
`include "atan2_full_circle_approx_core_macros.svh"

module atan2_fca_reduce import atan2_fca_pkg::*; #(
  parameter int INPUT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic signed [INPUT_BITS-1:0] y_i,
  input  logic signed [INPUT_BITS-1:0] x_i,
  output logic                         valid_o,
  output logic [INPUT_BITS:0]          num_o,
  output logic [INPUT_BITS:0]          den_o,
  output meta_t                        meta_o
);

  localparam int IB = INPUT_BITS;
  localparam int DW = INPUT_BITS + 1;
  localparam int CW = INPUT_BITS + 18;

  logic [2:0] v_q;

  logic [IB-1:0] ay_d, ax_d, ay1_q, ax1_q, ay2_q, ax2_q;
  meta_t         meta1_d, meta1_q, meta2_q, meta3_d, meta3_q;
  logic          gt3_d, gt1_d, ge_d, gt3_q, gt1_q, ge_q;
  logic [DW-1:0] num_d, den_d, num_q, den_q;

  // stage 1: magnitudes; most negative input maps to 2^(IB-1) exactly
  always_comb begin
    ay_d = y_i[IB-1] ? IB'(~$unsigned(y_i) + 1'b1) : $unsigned(y_i);
    ax_d = x_i[IB-1] ? IB'(~$unsigned(x_i) + 1'b1) : $unsigned(x_i);
    meta1_d.zero_x = (x_i == '0);
    meta1_d.x_neg  = x_i[IB-1];
    meta1_d.y_neg  = y_i[IB-1];
    meta1_d.ofs    = OFS_ZERO;
  end

  // stage 2: exact threshold compares, |y|*2^16 against T*|x|
  always_comb begin
    gt3_d = (CW'({ay1_q, 16'h0000}) > CW'(TAN_3PI8_Q16) * CW'(ax1_q));
    gt1_d = (CW'({ay1_q, 16'h0000}) > CW'(TAN_PI8_Q16) * CW'(ax1_q));
    ge_d  = (ay1_q >= ax1_q);
  end

  // stage 3: numerator / denominator of z, offset code
  always_comb begin
    meta3_d = meta2_q;
    priority if (gt3_q) begin
      num_d       = DW'(ax2_q);
      den_d       = DW'(ay2_q);
      meta3_d.ofs = OFS_PI2_SUB;
    end else if (gt1_q) begin
      den_d = DW'(ay2_q) + DW'(ax2_q);
      if (ge_q) begin
        num_d       = DW'(ay2_q - ax2_q);
        meta3_d.ofs = OFS_PI4_ADD;
      end else begin
        num_d       = DW'(ax2_q - ay2_q);
        meta3_d.ofs = OFS_PI4_SUB;
      end
    end else begin
      num_d       = DW'(ay2_q);
      den_d       = DW'(ax2_q);
      meta3_d.ofs = OFS_ZERO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ay1_q   <= ay_d;
      ax1_q   <= ax_d;
      meta1_q <= meta1_d;
      ay2_q   <= ay1_q;
      ax2_q   <= ax1_q;
      gt3_q   <= gt3_d;
      gt1_q   <= gt1_d;
      ge_q    <= ge_d;
      meta2_q <= meta1_q;
      num_q   <= num_d;
      den_q   <= den_d;
      meta3_q <= meta3_d;
    end
  end

  assign valid_o = v_q[2];
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign meta_o  = meta3_q;

  // z must be a proper fraction for the divider's quotient width
  `AFC_ASSERT(num_below_den_a, valid_o && !meta_o.zero_x, num_o < den_o, "z operand >= 1")

endmodule

`default_nettype wire

>>> rtl/core/atan2_fca_div.sv
// ---------------------------------------------------------------------------
// atan2_fca_div
// Pipelined restoring divider, num * 2^30 / den, DIV_BPS bits per stage.
// ---------------------------------------------------------------------------
`default_nettype none

module atan2_fca_div import atan2_fca_pkg::*; #(
  parameter int INPUT_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [INPUT_BITS:0] num_i,
  input  logic [INPUT_BITS:0] den_i,
  input  meta_t               meta_i,
  output logic                valid_o,
  output logic [WQ-1:0]       quo_o,
  output meta_t               meta_o
);

  localparam int DW = INPUT_BITS + 1;

  logic [DIV_STAGES-1:0] v_q;
  logic [DW-1:0]         rem_q  [DIV_STAGES];
  logic [DW-1:0]         den_q  [DIV_STAGES];
  logic [WQ-1:0]         quo_q  [DIV_STAGES];
  meta_t                 meta_q [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in, den_in, rem_nx;
    logic [WQ-1:0] quo_in, quo_nx;
    meta_t         meta_in;
    logic [DW:0]   rem2;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign meta_in = meta_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign den_in  = den_q[g-1];
      assign quo_in  = quo_q[g-1];
      assign meta_in = meta_q[g-1];
    end

    always_comb begin
      rem_nx = rem_in;
      quo_nx = quo_in;
      rem2   = '0;
      for (int b = 0; b < DIV_BPS; b++) begin
        rem2 = {rem_nx, 1'b0};
        if (rem2 >= {1'b0, den_in}) begin
          rem2   = rem2 - {1'b0, den_in};
          rem_nx = rem2[DW-1:0];
          quo_nx = {quo_nx[WQ-2:0], 1'b1};
        end else begin
          rem_nx = rem2[DW-1:0];
          quo_nx = {quo_nx[WQ-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_nx;
        den_q[g]  <= den_in;
        quo_q[g]  <= quo_nx;
        meta_q[g] <= meta_in;
      end
    end
  end

  assign valid_o = v_q[DIV_STAGES-1];
  assign quo_o   = quo_q[DIV_STAGES-1];
  assign meta_o  = meta_q[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> rtl/core/atan2_fca_poly.sv
// ---------------------------------------------------------------------------
// atan2_fca_poly
// Odd polynomial z + z^3*(-c1 + c3 w - c5 w^2 + c7 w^3), Horner, 7 stages.
// ---------------------------------------------------------------------------
`default_nettype none

module atan2_fca_poly import atan2_fca_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [WQ-1:0]        m_i,
  input  meta_t                meta_i,
  output logic                 valid_o,
  output logic signed [HW-1:0] poly_o,
  output meta_t                meta_o
);

  logic [6:0]           v_q;
  logic [PW-1:0]        prod_q [6];
  logic                 neg_q  [1:5];
  logic [MW-1:0]        w_q    [1:3];
  logic [WQ-1:0]        m_q    [6];
  meta_t                meta_q [7];
  logic signed [HW-1:0] poly_q;

  logic [MW-1:0]        w1_d;
  logic signed [HW-1:0] h2_d, h3_d, h4_d, h5_d, poly_d;

  always_comb begin
    w1_d   = rnd_mag(prod_q[0]);
    h2_d   = mul_round(neg_q[1], prod_q[1]) - C5_Q30;
    h3_d   = mul_round(neg_q[2], prod_q[2]) + C3_Q30;
    h4_d   = mul_round(neg_q[3], prod_q[3]) - C1_Q30;
    h5_d   = mul_round(neg_q[4], prod_q[4]);
    poly_d = mul_round(neg_q[5], prod_q[5]) + $signed({2'b00, m_q[5]});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // w = z^2
      prod_q[0] <= PW'(m_i) * PW'(m_i);
      m_q[0]    <= m_i;
      meta_q[0] <= meta_i;
      // c7 * w
      w_q[1]    <= w1_d;
      prod_q[1] <= PW'(mag_of(C7_Q30)) * PW'(w1_d);
      neg_q[1]  <= 1'b0;
      // Horner steps
      prod_q[2] <= PW'(mag_of(h2_d)) * PW'(w_q[1]);
      neg_q[2]  <= h2_d[HW-1];
      w_q[2]    <= w_q[1];
      prod_q[3] <= PW'(mag_of(h3_d)) * PW'(w_q[2]);
      neg_q[3]  <= h3_d[HW-1];
      w_q[3]    <= w_q[2];
      prod_q[4] <= PW'(mag_of(h4_d)) * PW'(w_q[3]);
      neg_q[4]  <= h4_d[HW-1];
      // times z
      prod_q[5] <= PW'(mag_of(h5_d)) * PW'(m_q[4]);
      neg_q[5]  <= h5_d[HW-1];
      poly_q    <= poly_d;
      for (int s = 1; s < 6; s++) begin
        m_q[s] <= m_q[s-1];
      end
      for (int s = 1; s < 7; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  assign valid_o = v_q[6];
  assign poly_o  = poly_q;
  assign meta_o  = meta_q[6];

endmodule

`default_nettype wire

>>> rtl/core/atan2_fca_quad.sv
// ---------------------------------------------------------------------------
// atan2_fca_quad
// Octant offset, quadrant fold, rounding to ANGLE_FRAC bits (3 stages).
// ---------------------------------------------------------------------------
`default_nettype none
`include "atan2_full_circle_approx_core_macros.svh"

module atan2_fca_quad import atan2_fca_pkg::*; #(
  parameter int ANGLE_FRAC = 13
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [HW-1:0] poly_i,
  input  meta_t                meta_i,
  output logic                 valid_o,
  output logic [OUT_W-1:0]     angle_o
);

  localparam int            SH       = WQ - ANGLE_FRAC;
  localparam logic [AW-1:0] HALF_LSB = AW'(1) << (SH - 1);
  localparam logic [AW-1:0] FULL     = (TWOPI_Q30 + HALF_LSB) >> SH;

  logic [2:0]           v_q;
  logic signed [SW-1:0] a_d, a_q, ang_s;
  logic [AW-1:0]        ang_d, ang_q, q_rnd, q_wrap;
  meta_t                meta1_q, meta2_q;
  logic [OUT_W-1:0]     angle_d, angle_q;
  logic                 zero_x_q;

  always_comb begin
    unique case (meta_i.ofs)
      OFS_ZERO:    a_d = SW'(poly_i);
      OFS_PI4_ADD: a_d = $signed({1'b0, PI4_Q30}) + SW'(poly_i);
      OFS_PI4_SUB: a_d = $signed({1'b0, PI4_Q30}) - SW'(poly_i);
      OFS_PI2_SUB: a_d = $signed({1'b0, PI2_Q30}) - SW'(poly_i);
      default:     a_d = SW'(poly_i);
    endcase
  end

  always_comb begin
    priority if (!meta1_q.x_neg && !meta1_q.y_neg) begin
      ang_s = a_q;
    end else if (meta1_q.x_neg && !meta1_q.y_neg) begin
      ang_s = $signed({1'b0, PI_Q30}) - a_q;
    end else if (meta1_q.x_neg && meta1_q.y_neg) begin
      ang_s = $signed({1'b0, PI_Q30}) + a_q;
    end else begin
      ang_s = $signed({1'b0, TWOPI_Q30}) - a_q;
    end
    ang_d = ang_s[SW-1] ? '0 : ang_s[AW-1:0];
  end

  // round half up, then wrap a full turn back to zero
  always_comb begin
    q_rnd  = (ang_q + HALF_LSB) >> SH;
    q_wrap = (q_rnd >= FULL) ? (q_rnd - FULL) : q_rnd;
    angle_d = meta2_q.zero_x ? '0 : q_wrap[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q      <= a_d;
      meta1_q  <= meta_i;
      ang_q    <= ang_d;
      meta2_q  <= meta1_q;
      angle_q  <= angle_d;
      zero_x_q <= meta2_q.zero_x;
    end
  end

  assign valid_o = v_q[2];
  assign angle_o = angle_q;

  `AFC_ASSERT(zero_x_gives_zero_a, valid_o && zero_x_q, angle_o == '0, "zero x not zero angle")

endmodule

`default_nettype wire

>>> rtl/core/atan2_full_circle_approx_core.sv
// ---------------------------------------------------------------------------
// atan2_full_circle_approx_core
// Full-circle angle of a signed (y, x) pair, odd-polynomial atan2, fixed point.
// ---------------------------------------------------------------------------
//
//  beat     | handshake         | payload
//  ---------+-------------------+-----------------------------------------
//  input    | valid_i / stall_o | y_value_i, x_value_i (INPUT_BITS, signed)
//  output   | valid_o / stall_i | angle_o (16 bits, rad * 2^ANGLE_FRAC)
//
//  One beat per clock in and out while no output beat is stalled. The
//  pipeline has 3 reduction stages, 15 divider stages (2 quotient bits each,
//  the long path), 7 polynomial stages, 3 offset/quadrant/rounding stages.
//  Reset clears only the valid bits; payload registers hold garbage.
//  A stalled output beat freezes the whole pipeline (one common enable), so
//  stall_o follows stall_i in the same cycle while the output holds a beat.
// ---------------------------------------------------------------------------
`default_nettype none
`include "atan2_full_circle_approx_core_macros.svh"

module atan2_full_circle_approx_core import atan2_fca_pkg::*; #(
  parameter int INPUT_BITS = 16,
  parameter int ANGLE_FRAC = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         stall_o,
  input  logic signed [INPUT_BITS-1:0] y_value_i,
  input  logic signed [INPUT_BITS-1:0] x_value_i,
  output logic                         valid_o,
  input  logic                         stall_i,
  output logic [OUT_W-1:0]             angle_o
);

  localparam int            SH       = WQ - ANGLE_FRAC;
  localparam logic [AW-1:0] FULL_ANG = (TWOPI_Q30 + (AW'(1) << (SH - 1))) >> SH;

  // pipeline moves unless a finished beat is held at the output
  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  logic                  red_v;
  logic [INPUT_BITS:0]   red_num, red_den;
  meta_t                 red_meta;

  logic                  div_v;
  logic [WQ-1:0]         div_quo;
  meta_t                 div_meta;

  logic                  poly_v;
  logic signed [HW-1:0]  poly_val;
  meta_t                 poly_meta;

  // |y|, |x|, octant choice, divider operands
  atan2_fca_reduce #(
    .INPUT_BITS(INPUT_BITS)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(valid_i),
    .y_i    (y_value_i),
    .x_i    (x_value_i),
    .valid_o(red_v),
    .num_o  (red_num),
    .den_o  (red_den),
    .meta_o (red_meta)
  );

  // z in Q30 by truncating division
  atan2_fca_div #(
    .INPUT_BITS(INPUT_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(red_v),
    .num_i  (red_num),
    .den_i  (red_den),
    .meta_i (red_meta),
    .valid_o(div_v),
    .quo_o  (div_quo),
    .meta_o (div_meta)
  );

  // atan(z) polynomial
  atan2_fca_poly u_poly (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(div_v),
    .m_i    (div_quo),
    .meta_i (div_meta),
    .valid_o(poly_v),
    .poly_o (poly_val),
    .meta_o (poly_meta)
  );

  // offset, quadrant, output rounding; its last register is the output
  atan2_fca_quad #(
    .ANGLE_FRAC(ANGLE_FRAC)
  ) u_quad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(poly_v),
    .poly_i (poly_val),
    .meta_i (poly_meta),
    .valid_o(valid_o),
    .angle_o(angle_o)
  );

  // the wrap step keeps every angle below one full turn
  `AFC_ASSERT(angle_below_turn_a, valid_o, AW'(angle_o) < FULL_ANG, "angle reached 2*pi")

endmodule

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// atan2 full-circle core testbench
// Directed table of corner vectors, then random vectors, all checked against
// a fixed-point angle predictor; random idling on both sides plus one long
// output hold-off so the pipeline fills and back-pressures its input.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
  import atan2_fca_pkg::*;

  localparam int IB        = 16;
  localparam int AF        = 13;
  localparam int N_RANDOM  = 1500;
  localparam int LATENCY   = 28;
  localparam int WDOG_MAX  = 4000;
  localparam int HOLD_CYC  = 200;

  localparam logic [63:0] HALF = 64'd1 << 29;
  localparam logic [63:0] K_T1 = 64'd27146;
  localparam logic [63:0] K_T3 = 64'd158218;
  localparam longint K_C7 = 86476423;
  localparam longint K_C5 = 149010514;
  localparam longint K_C3 = 214509035;
  localparam longint K_C1 = 357909816;
  localparam longint K_PI4 = 843314857;
  localparam longint K_PI2 = 1686629713;
  localparam longint K_PI = 64'sd3373259426;
  localparam longint K_2PI = 64'sd6746518852;

  // expected angle unknown until predicted
  localparam int NO_GOLD = -1;

  typedef struct {
    logic signed [IB-1:0] y;
    logic signed [IB-1:0] x;
    int                   gold;
  } vec_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 valid_i = 1'b0;
  logic                 stall_i = 1'b0;
  logic signed [IB-1:0] y_value_i = '0;
  logic signed [IB-1:0] x_value_i = '0;
  logic                 stall_o;
  logic                 valid_o;
  logic [OUT_W-1:0]     angle_o;

  logic [15:0] angle_q[$];
  int          n_err = 0;
  int          idle_cyc = 0;
  bit          hold_done = 1'b0;

  atan2_full_circle_approx_core #(.INPUT_BITS(IB), .ANGLE_FRAC(AF)) DUT (
    .clk_i, .rst_ni, .valid_i, .stall_o, .y_value_i, .x_value_i,
    .valid_o, .stall_i, .angle_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Q30 signed times Q30 magnitude, rounded half away from zero
  function automatic longint q30_mul(longint a, logic [63:0] b);
    logic [63:0] ua;
    logic [63:0] r;
    ua = (a < 0) ? 64'(-a) : 64'(a);
    r  = (ua * b + HALF) >> 30;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint odd_poly(logic [63:0] m);
    logic [63:0] w;
    longint      h;
    w = (m * m + HALF) >> 30;
    h = K_C7;
    h = q30_mul(h, w) - K_C5;
    h = q30_mul(h, w) + K_C3;
    h = q30_mul(h, w) - K_C1;
    h = q30_mul(h, w);
    return q30_mul(h, m) + longint'(m);
  endfunction

  function automatic logic [15:0] predict_angle(logic signed [IB-1:0] y,
                                                logic signed [IB-1:0] x);
    logic [63:0] ay;
    logic [63:0] ax;
    longint      a;
    longint      ang;
    logic [63:0] q;
    logic [63:0] full;
    ay = (y < 0) ? 64'(-longint'(y)) : 64'(y);
    ax = (x < 0) ? 64'(-longint'(x)) : 64'(x);
    if (ax == 0) return 16'd0;
    // sector reduction at tan(3pi/8) and tan(pi/8)
    if ((ay << 16) > K_T3 * ax) a = K_PI2 - odd_poly((ax << 30) / ay);
    else if ((ay << 16) > K_T1 * ax) begin
      if (ay >= ax) a = K_PI4 + odd_poly(((ay - ax) << 30) / (ay + ax));
      else a = K_PI4 - odd_poly(((ax - ay) << 30) / (ay + ax));
    end else a = odd_poly((ay << 30) / ax);
    if (x >= 0 && y >= 0) ang = a;
    else if (x < 0 && y >= 0) ang = K_PI - a;
    else if (x < 0) ang = K_PI + a;
    else ang = K_2PI - a;
    if (ang < 0) ang = 0;
    q    = (64'(ang) + (64'd1 << 16)) >> 17;
    full = (64'(K_2PI) + (64'd1 << 16)) >> 17;
    if (q >= full) q -= full;
    return q[15:0];
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
    n_err++;
  endtask

  // valid stays high across back-to-back beats; it drops only for a gap
  task automatic send_beat(logic signed [IB-1:0] y, logic signed [IB-1:0] x, int gold);
    int          gap;
    logic [15:0] p;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i   <= 1'b1;
    y_value_i <= y;
    x_value_i <= x;
    p = predict_angle(y, x);
    if (gold != NO_GOLD && int'(p) != gold) report_mismatch("table row", p, gold);
    do @(posedge clk_i); while (stall_o);
    angle_q.push_back(p);
  endtask

  // output side: per-beat random wait, one long hold-off once the feed is busy
  initial begin
    int          n_acc;
    int          wait_cyc;
    logic [15:0] want;
    n_acc = 0;
    wait_cyc = $urandom_range(0, 9);
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (valid_o && !stall_i) begin
        if (angle_q.size() == 0) report_mismatch("unexpected beat", angle_o, 0);
        else begin
          want = angle_q.pop_front();
          if (angle_o !== want) report_mismatch("angle", angle_o, want);
        end
        n_acc++;
        wait_cyc = (n_acc > 600 && n_acc < 900) ? 0 : $urandom_range(0, 9);
      end
      if (n_acc == 300 && !hold_done) begin
        hold_done = 1'b1;
        stall_i <= 1'b1;
        repeat (HOLD_CYC) @(posedge clk_i);
        stall_i <= 1'b0;
      end else if (wait_cyc > 0) begin
        stall_i <= 1'b1;
        wait_cyc--;
      end else stall_i <= 1'b0;
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WDOG_MAX) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    vec_row_t rows[$];
    logic signed [IB-1:0] ry;
    logic signed [IB-1:0] rx;
    int k;
    // corners: zero x, axes, most negative values, near-2pi wrap
    rows = '{
      '{16'sd0, 16'sd0, 0}, '{16'sd1234, 16'sd0, 0}, '{-16'sd32768, 16'sd0, 0},
      '{16'sd0, 16'sd100, 0}, '{16'sd0, 16'sd32767, 0}, '{16'sd0, -16'sd1, 25736},
      '{16'sd0, -16'sd32768, 25736}, '{-16'sd1, 16'sd32767, 0},
      '{-16'sd32768, -16'sd32768, NO_GOLD}, '{16'sd32767, 16'sd32767, NO_GOLD},
      '{16'sd32767, -16'sd32768, NO_GOLD}, '{-16'sd32768, 16'sd1, NO_GOLD},
      '{16'sd32767, 16'sd1, NO_GOLD}, '{16'sd1, -16'sd32768, NO_GOLD},
      '{-16'sd13573, -16'sd32768, NO_GOLD}, '{16'sd13573, -16'sd32768, NO_GOLD},
      '{16'sd13574, 16'sd32767, NO_GOLD}, '{16'sd31643, 16'sd13107, NO_GOLD},
      '{-16'sd5, 16'sd12, NO_GOLD}, '{-16'sd12, -16'sd5, NO_GOLD},
      '{16'sd3, -16'sd7, NO_GOLD}, '{-16'sd1, 16'sd1, NO_GOLD}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_beat(rows[i].y, rows[i].x, rows[i].gold);
    for (int n = 0; n < N_RANDOM; n++) begin
      k = $urandom_range(0, 9);
      ry = 16'($urandom);
      rx = 16'($urandom);
      if (k == 0) begin
        ry = ry >>> $urandom_range(0, 15);
        rx = rx >>> $urandom_range(0, 15);
      end else if (k == 1) rx = ry + $signed(4'($urandom));
      else if (k == 2) ry = $urandom_range(0, 1) ? 16'sd0 : ry;
      // bursts of back-to-back beats fall out of the gap draw
      send_beat(ry, rx, NO_GOLD);
    end
    valid_i <= 1'b0;
    wait (angle_q.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_err == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
+incdir+rtl/core
rtl/core/atan2_fca_pkg.sv
rtl/core/atan2_fca_reduce.sv
rtl/core/atan2_fca_div.sv
rtl/core/atan2_fca_poly.sv
rtl/core/atan2_fca_quad.sv
rtl/core/atan2_full_circle_approx_core.sv
verif/testbench.sv
